FILE: hw/rtl/sks_pkg.sv
package sks_pkg;

	// configuration register widths
	localparam int CfgW = 31;
	localparam int WgtW = 4;

	// field and accumulator widths
	localparam int PosW  = 32;
	localparam int SumW  = 48;
	localparam int CntW  = 7;
	localparam int VecW  = 50;

	// shared arithmetic units
	localparam int MulW  = 33;
	localparam int ProdW = 2 * MulW;
	localparam int DivW  = 64;
	localparam int RootW = 32;

	// stream payload widths
	localparam int InDataW  = 64;
	localparam int InUserW  = 2;
	localparam int OutDataW = 136;

	// register indexes
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_RADIUS      = 3'd0;
	localparam reg_idx_t REG_MAX_SPEED   = 3'd1;
	localparam reg_idx_t REG_MAX_FORCE   = 3'd2;
	localparam reg_idx_t REG_SEP_WEIGHT  = 3'd3;
	localparam reg_idx_t REG_SEEK_WEIGHT = 3'd4;

	// item kinds
	typedef logic [InUserW-1:0] cmd_t;
	localparam cmd_t CMD_NEIGHBOR = 2'd0;
	localparam cmd_t CMD_STEP     = 2'd1;
	localparam cmd_t CMD_PLACE    = 2'd2;

	// register reset values
	localparam logic [CfgW-1:0] RADIUS_RST    = 31'd786432;
	localparam logic [CfgW-1:0] MAX_SPEED_RST = 31'd196608;
	localparam logic [CfgW-1:0] MAX_FORCE_RST = 31'd13107;
	localparam logic [WgtW-1:0] SEP_WEIGHT_RST  = 4'd2;
	localparam logic [WgtW-1:0] SEEK_WEIGHT_RST = 4'd1;

endpackage

FILE: hw/rtl/sks_mul.sv
module sks_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sks_pkg::MulW-1:0]  a,
	input  logic [sks_pkg::MulW-1:0]  b,
	output logic                      busy,
	output logic [sks_pkg::ProdW-1:0] prod
);
	import sks_pkg::*;

	logic [ProdW-1:0] acc_q;
	logic [ProdW-1:0] mcand_q;
	logic [MulW-1:0]  mplier_q;
	logic             busy_q;

	// run until the multiplier bits are used up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= (b != '0);
		end else if (busy_q) begin
			busy_q <= (mplier_q[MulW-1:1] != '0);
		end
	end

	// add the shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= ProdW'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[ProdW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MulW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

FILE: hw/rtl/sks_div.sv
module sks_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [sks_pkg::DivW-1:0] num,
	input  logic [sks_pkg::DivW-1:0] den,
	output logic                     busy,
	output logic [sks_pkg::DivW-1:0] quo
);
	import sks_pkg::*;

	localparam int CntBits = $clog2(DivW + 1);

	logic [DivW-1:0]    rem_q;
	logic [DivW-1:0]    quo_q;
	logic [DivW-1:0]    den_q;
	logic [CntBits-1:0] cnt_q;
	logic               busy_q;
	logic [DivW:0]      trial;
	logic               fits;

	// one restoring step: bring down the next dividend bit
	assign trial = {rem_q, quo_q[DivW-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntBits'(DivW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CntBits'(1));
			cnt_q  <= cnt_q - CntBits'(1);
		end
	end

	// shift quotient bits in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) rem_q <= DivW'(trial - {1'b0, den_q});
			else rem_q <= trial[DivW-1:0];
			quo_q <= {quo_q[DivW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

FILE: hw/rtl/sks_sqrt.sv
module sks_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [2*sks_pkg::RootW-1:0] rad,
	output logic                        busy,
	output logic [sks_pkg::RootW-1:0]   root
);
	import sks_pkg::*;

	localparam int CntBits = $clog2(RootW + 1);

	logic [2*RootW-1:0] n_q;
	logic [RootW+1:0]   rem_q;
	logic [RootW-1:0]   root_q;
	logic [CntBits-1:0] cnt_q;
	logic               busy_q;
	logic [RootW+3:0]   acc;
	logic [RootW+3:0]   trial;
	logic               fits;

	// one root bit per cycle from the next pair of radicand bits
	assign acc   = {rem_q, n_q[2*RootW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = (acc >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntBits'(RootW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CntBits'(1));
			cnt_q  <= cnt_q - CntBits'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[2*RootW-3:0], 2'b00};
			if (fits) rem_q <= (RootW+2)'(acc - trial);
			else rem_q <= (RootW+2)'(acc);
			root_q <= {root_q[RootW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

FILE: hw/rtl/steering_seek_separation_step.sv
// Steering agent with seek and separation, one agent per instance.
// Input stream: tuser carries the item kind (neighbor, step, place), tdata the
// point (pos_x low, pos_y high). Output stream: one transfer per step item with
// the new position, new velocity and the neighbor count of that step.
// Configuration: cfg_en writes cfg_data into the register cfg_index selects;
// write only while the block is idle.
// Timing: all arithmetic runs on one shift-add multiplier, one restoring
// divider and one square root unit, each retiring one bit (root: one bit from
// two radicand bits) per cycle. A neighbor item in range needs three squares
// and two 64-bit quotients. A step item runs up to five vector normalizations
// and three length checks.
// Items are taken one at a time; s_axis_tready is high only while idle.
// Place items and unknown kinds are handled in the idle state and give no transfer.
// Reset puts the agent at the origin with velocity (3.0, 0), clears the
// accumulators and loads the register defaults. A result waits in the output
// register while the receiver stalls; the next item is still accepted, but the
// following step holds its result until the output register frees up.
module steering_seek_separation_step #(
	parameter int MAX_NEIGHBORS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_en,
	input  sks_pkg::reg_idx_t            cfg_index,
	input  logic [sks_pkg::CfgW-1:0]     cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [sks_pkg::InDataW-1:0]  s_axis_tdata,  // pos_x, pos_y
	input  logic [sks_pkg::InUserW-1:0]  s_axis_tuser,  // cmd
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [sks_pkg::OutDataW-1:0] m_axis_tdata   // loc_x, loc_y, vel_x, vel_y, near_count
);
	import sks_pkg::*;

	localparam int CapN = (MAX_NEIGHBORS < 127) ? MAX_NEIGHBORS : 127;
	localparam logic [CntW-1:0] CAP = CntW'(CapN);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_N_DIFF, ST_N_SQX, ST_N_SQY, ST_N_LIM, ST_N_DIVX, ST_N_DIVY,
		ST_S_START, ST_S_SEPSUB, ST_S_SEPSAVE, ST_S_SEEK, ST_S_SKSUB, ST_S_SKSAVE,
		ST_S_MOVE,
		ST_M_INIT, ST_M_NORM, ST_M_SQX, ST_M_SQY, ST_M_ROOT, ST_M_MX, ST_M_DX,
		ST_M_MY, ST_M_DY,
		ST_L_INIT, ST_L_SQX, ST_L_SQY, ST_L_L2
	} state_t;

	state_t state_q, ret_q;

	// registers and agent state
	logic [CfgW-1:0] radius_q, max_speed_q, max_force_q;
	logic [WgtW-1:0] sep_weight_q, seek_weight_q;
	logic signed [PosW-1:0] agent_x_q, agent_y_q, speed_x_q, speed_y_q;
	logic signed [SumW-1:0] push_sum_x_q, push_sum_y_q;
	logic [CntW-1:0] push_count_q;

	// working registers
	logic signed [PosW-1:0] px_q, py_q;
	logic signed [VecW-1:0] vx_q, vy_q, sep_x_q, sep_y_q;
	logic [VecW-1:0]  nx_q, ny_q;
	logic [ProdW-1:0] sq_q;
	logic [RootW-1:0] len_q;
	logic [CfgW-1:0]  mag_q;
	logic [DivW-1:0]  qx_q;

	// unit handshakes
	logic             mul_go_q, div_go_q, root_go_q;
	logic [MulW-1:0]  mul_a_q, mul_b_q;
	logic [DivW-1:0]  div_num_q, div_den_q;
	logic [DivW-1:0]  root_rad_q;
	logic             mul_busy, div_busy, root_busy;
	logic             mul_done, div_done, root_done;
	logic [ProdW-1:0] mul_p;
	logic [DivW-1:0]  div_q;
	logic [RootW-1:0] root_res;

	// output register
	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	// combinational helpers
	logic [VecW-1:0]        abs_x, abs_y, big;
	logic [PosW-1:0]        rr;
	logic signed [SumW+1:0] term_x, term_y, acc_x, acc_y;
	logic signed [PosW+1:0] pos_x_sum, pos_y_sum;
	logic signed [VecW-1:0] new_vx, new_vy;

	sks_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.busy(mul_busy), .prod(mul_p)
	);

	sks_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(div_num_q), .den(div_den_q),
		.busy(div_busy), .quo(div_q)
	);

	sks_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(root_go_q), .rad(root_rad_q),
		.busy(root_busy), .root(root_res)
	);

	function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW+1:0] v);
		logic signed [SumW-1:0] r;
		if (v[SumW+1:SumW-1] == 3'b000 || v[SumW+1:SumW-1] == 3'b111) r = v[SumW-1:0];
		else if (v[SumW+1]) r = {1'b1, {(SumW-1){1'b0}}};
		else r = {1'b0, {(SumW-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW+1:0] v);
		logic signed [PosW-1:0] r;
		if (v[PosW+1:PosW-1] == 3'b000 || v[PosW+1:PosW-1] == 3'b111) r = v[PosW-1:0];
		else if (v[PosW+1]) r = {1'b1, {(PosW-1){1'b0}}};
		else r = {1'b0, {(PosW-1){1'b1}}};
		return r;
	endfunction

	assign mul_done  = !mul_go_q && !mul_busy;
	assign div_done  = !div_go_q && !div_busy;
	assign root_done = !root_go_q && !root_busy;

	// magnitudes of the working vector
	assign abs_x = vx_q[VecW-1] ? VecW'(-vx_q) : VecW'(vx_q);
	assign abs_y = vy_q[VecW-1] ? VecW'(-vy_q) : VecW'(vy_q);
	assign big   = (nx_q > ny_q) ? nx_q : ny_q;
	assign rr    = {radius_q, 1'b0};

	// signed repulsion terms and saturating sums
	assign term_x = vx_q[VecW-1] ? -(SumW+2)'(qx_q[PosW:0]) : (SumW+2)'(qx_q[PosW:0]);
	assign term_y = vy_q[VecW-1] ? -(SumW+2)'(div_q[PosW:0]) : (SumW+2)'(div_q[PosW:0]);
	assign acc_x  = (SumW+2)'(push_sum_x_q) + term_x;
	assign acc_y  = (SumW+2)'(push_sum_y_q) + term_y;

	// position advance
	assign pos_x_sum = (PosW+2)'(agent_x_q) + (PosW+2)'(vx_q);
	assign pos_y_sum = (PosW+2)'(agent_y_q) + (PosW+2)'(vy_q);

	// weighted velocity update
	assign new_vx = VecW'(speed_x_q) + sep_x_q * $signed({1'b0, sep_weight_q})
		+ vx_q * $signed({1'b0, seek_weight_q});
	assign new_vy = VecW'(speed_y_q) + sep_y_q * $signed({1'b0, sep_weight_q})
		+ vy_q * $signed({1'b0, seek_weight_q});

	// sequencer, agent state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ret_q         <= ST_IDLE;
			radius_q      <= RADIUS_RST;
			max_speed_q   <= MAX_SPEED_RST;
			max_force_q   <= MAX_FORCE_RST;
			sep_weight_q  <= SEP_WEIGHT_RST;
			seek_weight_q <= SEEK_WEIGHT_RST;
			agent_x_q     <= '0;
			agent_y_q     <= '0;
			speed_x_q     <= PosW'(MAX_SPEED_RST);
			speed_y_q     <= '0;
			push_sum_x_q  <= '0;
			push_sum_y_q  <= '0;
			push_count_q  <= '0;
			px_q          <= '0;
			py_q          <= '0;
			vx_q          <= '0;
			vy_q          <= '0;
			sep_x_q       <= '0;
			sep_y_q       <= '0;
			nx_q          <= '0;
			ny_q          <= '0;
			sq_q          <= '0;
			len_q         <= '0;
			mag_q         <= '0;
			qx_q          <= '0;
			mul_go_q      <= 1'b0;
			div_go_q      <= 1'b0;
			root_go_q     <= 1'b0;
			mul_a_q       <= '0;
			mul_b_q       <= '0;
			div_num_q     <= '0;
			div_den_q     <= '0;
			root_rad_q    <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			mul_go_q  <= 1'b0;
			div_go_q  <= 1'b0;
			root_go_q <= 1'b0;

			// drop the result once the receiver takes it, unless a new one lands
			if (m_axis_tready && state_q != ST_S_MOVE) out_valid_q <= 1'b0;

			// register writes
			if (cfg_en) begin
				unique case (cfg_index)
					REG_RADIUS:      radius_q      <= cfg_data;
					REG_MAX_SPEED:   max_speed_q   <= cfg_data;
					REG_MAX_FORCE:   max_force_q   <= cfg_data;
					REG_SEP_WEIGHT:  sep_weight_q  <= cfg_data[WgtW-1:0];
					REG_SEEK_WEIGHT: seek_weight_q <= cfg_data[WgtW-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						px_q <= s_axis_tdata[PosW-1:0];
						py_q <= s_axis_tdata[2*PosW-1:PosW];
						unique case (s_axis_tuser)
							CMD_NEIGHBOR: begin
								vx_q <= VecW'(agent_x_q) - VecW'($signed(s_axis_tdata[PosW-1:0]));
								vy_q <= VecW'(agent_y_q)
									- VecW'($signed(s_axis_tdata[2*PosW-1:PosW]));
								state_q <= ST_N_DIFF;
							end
							CMD_STEP: state_q <= ST_S_START;
							CMD_PLACE: begin
								agent_x_q    <= s_axis_tdata[PosW-1:0];
								agent_y_q    <= s_axis_tdata[2*PosW-1:PosW];
								speed_x_q    <= PosW'(max_speed_q);
								speed_y_q    <= '0;
								push_sum_x_q <= '0;
								push_sum_y_q <= '0;
								push_count_q <= '0;
							end
							default: ;
						endcase
					end
				end

				// neighbor: range test, squared distance, repulsion quotients
				ST_N_DIFF: begin
					nx_q <= abs_x;
					ny_q <= abs_y;
					if (abs_x >= VecW'(rr) || abs_y >= VecW'(rr)) begin
						state_q <= ST_IDLE;
					end else begin
						mul_a_q  <= MulW'(abs_x);
						mul_b_q  <= MulW'(abs_x);
						mul_go_q <= 1'b1;
						state_q  <= ST_N_SQX;
					end
				end
				ST_N_SQX: if (mul_done) begin
					sq_q     <= mul_p;
					mul_a_q  <= MulW'(ny_q);
					mul_b_q  <= MulW'(ny_q);
					mul_go_q <= 1'b1;
					state_q  <= ST_N_SQY;
				end
				ST_N_SQY: if (mul_done) begin
					sq_q     <= sq_q + mul_p;
					mul_a_q  <= MulW'(rr);
					mul_b_q  <= MulW'(rr);
					mul_go_q <= 1'b1;
					state_q  <= ST_N_LIM;
				end
				ST_N_LIM: if (mul_done) begin
					if (sq_q >= mul_p || sq_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						div_num_q <= {nx_q[PosW-1:0], {PosW{1'b0}}};
						div_den_q <= sq_q[DivW-1:0];
						div_go_q  <= 1'b1;
						state_q   <= ST_N_DIVX;
					end
				end
				ST_N_DIVX: if (div_done) begin
					qx_q      <= div_q;
					div_num_q <= {ny_q[PosW-1:0], {PosW{1'b0}}};
					div_go_q  <= 1'b1;
					state_q   <= ST_N_DIVY;
				end
				ST_N_DIVY: if (div_done) begin
					push_sum_x_q <= sat_sum(acc_x);
					push_sum_y_q <= sat_sum(acc_y);
					if (push_count_q < CAP) push_count_q <= push_count_q + CntW'(1);
					state_q <= ST_IDLE;
				end

				// step: separation, seek, velocity and position update
				ST_S_START: begin
					if (push_count_q != '0) begin
						vx_q    <= VecW'(push_sum_x_q);
						vy_q    <= VecW'(push_sum_y_q);
						mag_q   <= max_speed_q;
						ret_q   <= ST_S_SEPSUB;
						state_q <= ST_M_INIT;
					end else begin
						sep_x_q <= '0;
						sep_y_q <= '0;
						state_q <= ST_S_SEEK;
					end
				end
				ST_S_SEPSUB: begin
					vx_q    <= vx_q - VecW'(speed_x_q);
					vy_q    <= vy_q - VecW'(speed_y_q);
					mag_q   <= max_force_q;
					ret_q   <= ST_S_SEPSAVE;
					state_q <= ST_L_INIT;
				end
				ST_S_SEPSAVE: begin
					sep_x_q <= vx_q;
					sep_y_q <= vy_q;
					state_q <= ST_S_SEEK;
				end
				ST_S_SEEK: begin
					vx_q    <= VecW'(px_q) - VecW'(agent_x_q);
					vy_q    <= VecW'(py_q) - VecW'(agent_y_q);
					mag_q   <= max_speed_q;
					ret_q   <= ST_S_SKSUB;
					state_q <= ST_M_INIT;
				end
				ST_S_SKSUB: begin
					vx_q    <= vx_q - VecW'(speed_x_q);
					vy_q    <= vy_q - VecW'(speed_y_q);
					mag_q   <= max_force_q;
					ret_q   <= ST_S_SKSAVE;
					state_q <= ST_L_INIT;
				end
				ST_S_SKSAVE: begin
					vx_q    <= new_vx;
					vy_q    <= new_vy;
					mag_q   <= max_speed_q;
					ret_q   <= ST_S_MOVE;
					state_q <= ST_L_INIT;
				end
				ST_S_MOVE: if (!out_valid_q || m_axis_tready) begin
					speed_x_q    <= vx_q[PosW-1:0];
					speed_y_q    <= vy_q[PosW-1:0];
					agent_x_q    <= sat_pos(pos_x_sum);
					agent_y_q    <= sat_pos(pos_y_sum);
					out_data_q   <= {1'b0, push_count_q, vy_q[PosW-1:0], vx_q[PosW-1:0],
						sat_pos(pos_y_sum), sat_pos(pos_x_sum)};
					out_valid_q  <= 1'b1;
					push_sum_x_q <= '0;
					push_sum_y_q <= '0;
					push_count_q <= '0;
					state_q      <= ST_IDLE;
				end

				// scale the working vector to length mag_q
				ST_M_INIT: begin
					nx_q <= abs_x;
					ny_q <= abs_y;
					if (vx_q == '0 && vy_q == '0) state_q <= ret_q;
					else state_q <= ST_M_NORM;
				end
				ST_M_NORM: begin
					if (big[VecW-1:RootW-1] != '0) begin
						nx_q <= nx_q >> 1;
						ny_q <= ny_q >> 1;
					end else if (!big[RootW-2]) begin
						nx_q <= nx_q << 1;
						ny_q <= ny_q << 1;
					end else begin
						mul_a_q  <= MulW'(nx_q);
						mul_b_q  <= MulW'(nx_q);
						mul_go_q <= 1'b1;
						state_q  <= ST_M_SQX;
					end
				end
				ST_M_SQX: if (mul_done) begin
					sq_q     <= mul_p;
					mul_a_q  <= MulW'(ny_q);
					mul_b_q  <= MulW'(ny_q);
					mul_go_q <= 1'b1;
					state_q  <= ST_M_SQY;
				end
				ST_M_SQY: if (mul_done) begin
					root_rad_q <= DivW'(sq_q + mul_p);
					root_go_q  <= 1'b1;
					state_q    <= ST_M_ROOT;
				end
				ST_M_ROOT: if (root_done) begin
					len_q    <= root_res;
					mul_a_q  <= MulW'(nx_q);
					mul_b_q  <= MulW'(mag_q);
					mul_go_q <= 1'b1;
					state_q  <= ST_M_MX;
				end
				ST_M_MX: if (mul_done) begin
					div_num_q <= DivW'(mul_p);
					div_den_q <= DivW'(len_q);
					div_go_q  <= 1'b1;
					state_q   <= ST_M_DX;
				end
				ST_M_DX: if (div_done) begin
					qx_q     <= div_q;
					mul_a_q  <= MulW'(ny_q);
					mul_b_q  <= MulW'(mag_q);
					mul_go_q <= 1'b1;
					state_q  <= ST_M_MY;
				end
				ST_M_MY: if (mul_done) begin
					div_num_q <= DivW'(mul_p);
					div_go_q  <= 1'b1;
					state_q   <= ST_M_DY;
				end
				ST_M_DY: if (div_done) begin
					vx_q    <= vx_q[VecW-1] ? -VecW'(qx_q[PosW:0]) : VecW'(qx_q[PosW:0]);
					vy_q    <= vy_q[VecW-1] ? -VecW'(div_q[PosW:0]) : VecW'(div_q[PosW:0]);
					state_q <= ret_q;
				end

				// limit the working vector to length mag_q
				ST_L_INIT: begin
					nx_q <= abs_x;
					ny_q <= abs_y;
					if (abs_x[VecW-1:PosW] != '0 || abs_y[VecW-1:PosW] != '0) begin
						state_q <= ST_M_INIT;
					end else begin
						mul_a_q  <= MulW'(abs_x);
						mul_b_q  <= MulW'(abs_x);
						mul_go_q <= 1'b1;
						state_q  <= ST_L_SQX;
					end
				end
				ST_L_SQX: if (mul_done) begin
					sq_q     <= mul_p;
					mul_a_q  <= MulW'(ny_q);
					mul_b_q  <= MulW'(ny_q);
					mul_go_q <= 1'b1;
					state_q  <= ST_L_SQY;
				end
				ST_L_SQY: if (mul_done) begin
					sq_q     <= sq_q + mul_p;
					mul_a_q  <= MulW'(mag_q);
					mul_b_q  <= MulW'(mag_q);
					mul_go_q <= 1'b1;
					state_q  <= ST_L_L2;
				end
				ST_L_L2: if (mul_done) begin
					if (sq_q > mul_p) state_q <= ST_M_INIT;
					else state_q <= ret_q;
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: hw/rtl/sks_chk.sv
module sks_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic [sks_pkg::InUserW-1:0]  s_axis_tuser,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [sks_pkg::OutDataW-1:0] m_axis_tdata
);
	import sks_pkg::*;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one item at a time: a neighbor or step transfer blocks the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready
			&& (s_axis_tuser == CMD_NEIGHBOR || s_axis_tuser == CMD_STEP)
		|=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// a new result appears only while an item is being worked on
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result raised while idle");

endmodule

bind steering_seek_separation_step sks_chk u_sks_chk (.*);
